// ===== sv/mhpq_pkg.sv =====
// types, codes and defaults shared by the min-heap priority queue
`default_nettype none

package mhpq_pkg;

   localparam int unsigned HEAP_DEPTH_DEF = 256;
   localparam int unsigned KEY_W          = 32;
   localparam int unsigned PAY_W          = 9;
   localparam int unsigned CNT_OUT_W      = 9;

   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_UNDER = 2'd1;
   localparam logic [1:0] ST_OVER  = 2'd2;

   typedef struct packed {
      logic             op;
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0]     out_key;
      logic [PAY_W-1:0]     out_payload;
      logic [1:0]           status;
      logic [KEY_W-1:0]     min_key;
      logic                 is_empty_flag;
      logic [CNT_OUT_W-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } entry_type;

endpackage

`default_nettype wire

// ===== sv/mhpq_store.sv =====
// heap entry store: one write port, two registered read ports
`default_nettype none

module mhpq_store #(
   parameter int unsigned DEPTH = mhpq_pkg::HEAP_DEPTH_DEF,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [AW-1:0]       wr_addr,
   input  wire mhpq_pkg::entry_type wr_data,
   input  wire logic [AW-1:0]       rd_a_addr,
   input  wire logic [AW-1:0]       rd_b_addr,
   output mhpq_pkg::entry_type      rd_a_data,
   output mhpq_pkg::entry_type      rd_b_data
);
   import mhpq_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_a_ff;
   entry_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

`default_nettype wire

// ===== sv/min_heap_priority_queue.sv =====
// binary min-heap priority queue top level with sift sequencer
//
// usage: each req transaction is an enqueue (key, payload) or a dequeue.
// every req transaction yields exactly one rsp transaction carrying the
// dequeued pair (zero otherwise), a status (ok, underflow, overflow), the
// root key, an empty flag and the entry count after the operation.
// req and rsp use valid/stall handshakes; one operation is in flight at a
// time and req_stall stays high from acceptance until its result has been
// loaded into the rsp register, so the next req can be taken in the next cycle.
// overflow and underflow go straight to the result; an enqueue climbs from
// the new leaf toward the root, and a dequeue moves the last entry to the
// root and sifts it down toward the leaves. each heap level of the walk
// takes one store read state and one compare/write state.
// the rsp register frees the sequencer: the next req can be accepted while
// a result waits, but a second result waits in the sequencer while the rsp
// side stalls.
// reset empties the heap (count cleared); store contents are not cleared.
`default_nettype none

module min_heap_priority_queue #(
   parameter int unsigned HEAP_DEPTH = mhpq_pkg::HEAP_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire mhpq_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output mhpq_pkg::rsp_type      rsp_data
);
   import mhpq_pkg::*;

   localparam int unsigned AW = $clog2(HEAP_DEPTH);
   localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
   localparam int unsigned XW = AW + 2;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_UP_RD   = 7'b0000010,
      S_UP_CMP  = 7'b0000100,
      S_DN_LAST = 7'b0001000,
      S_DN_RD   = 7'b0010000,
      S_DN_CMP  = 7'b0100000,
      S_FIN     = 7'b1000000
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [AW-1:0]   pos_ff, pos_in;
   entry_type       item_ff, item_in;
   entry_type       root_ff, root_in;
   entry_type       deq_ff, deq_in;
   logic [1:0]      status_ff, status_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   entry_type       wr_data;
   logic [AW-1:0]   rd_a_addr;
   logic [AW-1:0]   rd_b_addr;
   entry_type       rd_a_data;
   entry_type       rd_b_data;

   logic [XW-1:0]   l_x;
   logic [XW-1:0]   r_x;
   logic [XW-1:0]   cnt_x;
   logic [AW-1:0]   parent;
   logic            l_take;
   logic            r_take;
   entry_type       best;
   logic [AW-1:0]   best_pos;

   mhpq_store #(
      .DEPTH(HEAP_DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   assign l_x    = {1'b0, pos_ff, 1'b1};
   assign r_x    = l_x + XW'(1);
   assign cnt_x  = XW'(cnt_ff);
   assign parent = AW'((pos_ff - AW'(1)) >> 1);

   // smaller child, left wins ties, only if strictly below the moving entry
   always_comb begin
      best     = item_ff;
      best_pos = pos_ff;
      l_take   = (l_x < cnt_x) && (rd_a_data.key < item_ff.key);
      if (l_take) begin
         best     = rd_a_data;
         best_pos = l_x[AW-1:0];
      end
      r_take = (r_x < cnt_x) && (rd_b_data.key < best.key);
      if (r_take) begin
         best     = rd_b_data;
         best_pos = r_x[AW-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      item_in      = item_ff;
      deq_in       = deq_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = item_ff;
      rd_a_addr    = l_x[AW-1:0];
      rd_b_addr    = r_x[AW-1:0];

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            rd_a_addr = AW'(cnt_ff - CW'(1));
            if (req_valid) begin
               deq_in    = '0;
               status_in = ST_OK;
               if (req_data.op == OP_ENQ) begin
                  if (cnt_ff == CW'(HEAP_DEPTH)) begin
                     status_in = ST_OVER;
                     state_in  = S_FIN;
                  end else begin
                     item_in  = '{key: req_data.key, payload: req_data.payload};
                     pos_in   = AW'(cnt_ff);
                     cnt_in   = cnt_ff + CW'(1);
                     state_in = S_UP_RD;
                  end
               end else begin
                  if (cnt_ff == '0) begin
                     status_in = ST_UNDER;
                     state_in  = S_FIN;
                  end else begin
                     deq_in   = root_ff;
                     cnt_in   = cnt_ff - CW'(1);
                     state_in = S_DN_LAST;
                  end
               end
            end
         end
         S_UP_RD: begin
            rd_a_addr = parent;
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = S_FIN;
            end else begin
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            wr_en = 1'b1;
            if (item_ff.key < rd_a_data.key) begin
               wr_data  = rd_a_data;
               pos_in   = parent;
               state_in = S_UP_RD;
            end else begin
               state_in = S_FIN;
            end
         end
         S_DN_LAST: begin
            item_in = rd_a_data;
            pos_in  = '0;
            if (cnt_ff == '0) begin
               state_in = S_FIN;
            end else begin
               state_in = S_DN_RD;
            end
         end
         S_DN_RD: begin
            if (l_x >= cnt_x) begin
               wr_en    = 1'b1;
               state_in = S_FIN;
            end else begin
               state_in = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            wr_en = 1'b1;
            if (l_take || r_take) begin
               wr_data  = best;
               pos_in   = best_pos;
               state_in = S_DN_RD;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in         = 1'b1;
               rsp_in.out_key       = deq_ff.key;
               rsp_in.out_payload   = deq_ff.payload;
               rsp_in.status        = status_ff;
               rsp_in.min_key       = (cnt_ff != '0) ? root_ff.key : '0;
               rsp_in.is_empty_flag = (cnt_ff == '0);
               rsp_in.entry_count   = CNT_OUT_W'(cnt_ff);
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // root shadow so the minimum is known without a store read
   always_comb begin
      root_in = root_ff;
      if (wr_en && (wr_addr == '0)) begin
         root_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      item_ff   <= item_in;
      root_ff   <= root_in;
      deq_ff    <= deq_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(HEAP_DEPTH))
      else $error("entry count beyond heap depth");

   a_wr_in_heap: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CW'(wr_addr) < cnt_ff))
      else $error("store write outside occupied entries");

   a_enq_count: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_data.op == OP_ENQ) && (cnt_ff != CW'(HEAP_DEPTH)))
      |=> (cnt_ff == $past(cnt_ff) + CW'(1)))
      else $error("enqueue did not grow the heap");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status != ST_OK))
      |-> ((rsp_ff.out_key == '0) && (rsp_ff.out_payload == '0)))
      else $error("error response carries a dequeued pair");

endmodule

`default_nettype wire

// ===== test/tb_min_heap_priority_queue.sv =====
// self-checking testbench for the min-heap priority queue with a heap scoreboard
`timescale 1ns / 100ps

module tb_min_heap_priority_queue;
   import mhpq_pkg::*;

   localparam int unsigned DEPTH       = HEAP_DEPTH_DEF;
   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned LONG_HOLD   = 80;
   localparam int unsigned ITEM_GOAL   = 600;

   class heap_scoreboard;
      logic [KEY_W-1:0] heap_keys [DEPTH];
      logic [PAY_W-1:0] heap_pays [DEPTH];
      int unsigned      fill;
      rsp_type          expected_results [$];
      int unsigned      errors;
      int unsigned      checked;
      int unsigned      n_enq;
      int unsigned      n_deq;
      int unsigned      n_over;
      int unsigned      n_under;
      int unsigned      peak;

      function new();
         fill = 0;
         errors = 0;
         checked = 0;
         n_enq = 0;
         n_deq = 0;
         n_over = 0;
         n_under = 0;
         peak = 0;
      endfunction

      function void swap_slots(int unsigned a, int unsigned b);
         logic [KEY_W-1:0] k;
         logic [PAY_W-1:0] p;
         k = heap_keys[a];
         p = heap_pays[a];
         heap_keys[a] = heap_keys[b];
         heap_pays[a] = heap_pays[b];
         heap_keys[b] = k;
         heap_pays[b] = p;
      endfunction

      // apply one accepted transaction to the heap copy and queue its result
      function void predict_op(req_type r);
         rsp_type     e;
         int unsigned pos;
         int unsigned up;
         int unsigned lo;
         int unsigned l;
         int unsigned rt;
         bit          done;
         e = '0;
         e.status = ST_OK;
         if (r.op == OP_ENQ) begin
            n_enq++;
            if (fill >= DEPTH) begin
               e.status = ST_OVER;
               n_over++;
            end else begin
               heap_keys[fill] = r.key;
               heap_pays[fill] = r.payload;
               pos = fill;
               fill++;
               done = 0;
               while (pos > 0 && !done) begin
                  up = (pos - 1) / 2;
                  if (heap_keys[pos] < heap_keys[up]) begin
                     swap_slots(pos, up);
                     pos = up;
                  end else begin
                     done = 1;
                  end
               end
            end
         end else begin
            n_deq++;
            if (fill == 0) begin
               e.status = ST_UNDER;
               n_under++;
            end else begin
               e.out_key = heap_keys[0];
               e.out_payload = heap_pays[0];
               fill--;
               heap_keys[0] = heap_keys[fill];
               heap_pays[0] = heap_pays[fill];
               pos = 0;
               done = 0;
               while (pos < fill && !done) begin
                  lo = pos;
                  l = 2 * pos + 1;
                  rt = 2 * pos + 2;
                  if (l < fill && heap_keys[l] < heap_keys[lo])
                     lo = l;
                  if (rt < fill && heap_keys[rt] < heap_keys[lo])
                     lo = rt;
                  if (lo == pos) begin
                     done = 1;
                  end else begin
                     swap_slots(pos, lo);
                     pos = lo;
                  end
               end
            end
         end
         if (fill > peak)
            peak = fill;
         e.min_key = (fill > 0) ? heap_keys[0] : '0;
         e.is_empty_flag = (fill == 0);
         e.entry_count = fill[CNT_OUT_W-1:0];
         expected_results.push_back(e);
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         bit      bad;
         if (expected_results.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: key=%h pay=%h st=%0d min=%h empty=%0d cnt=%0d",
                        a.out_key, a.out_payload, a.status, a.min_key, a.is_empty_flag,
                        a.entry_count);
            return;
         end
         e = expected_results.pop_front();
         checked++;
         bad = (a.out_key !== e.out_key) || (a.out_payload !== e.out_payload) ||
               (a.status !== e.status) || (a.min_key !== e.min_key) ||
               (a.is_empty_flag !== e.is_empty_flag) || (a.entry_count !== e.entry_count);
         if (bad) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch on result %0d", checked);
               $display("  expected: key=%h pay=%h st=%0d min=%h empty=%0d cnt=%0d",
                        e.out_key, e.out_payload, e.status, e.min_key, e.is_empty_flag,
                        e.entry_count);
               $display("  actual:   key=%h pay=%h st=%0d min=%h empty=%0d cnt=%0d",
                        a.out_key, a.out_payload, a.status, a.min_key, a.is_empty_flag,
                        a.entry_count);
            end
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   heap_scoreboard book;
   int unsigned    req_gap_max;
   int unsigned    rsp_stall_max;
   bit             long_hold_req;
   int unsigned    long_holds;
   int unsigned    sent;
   int unsigned    quiet;

   min_heap_priority_queue i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   function automatic logic [KEY_W-1:0] draw_key();
      logic [KEY_W-1:0] k;
      case ($urandom_range(0, 3))
         0: k = $urandom_range(0, 15);
         1: k = $urandom;
         2: k = $urandom_range(0, 1) ? '1 : '0;
         default: k = $urandom_range(0, 1000);
      endcase
      return k;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_req(input logic op, input logic [KEY_W-1:0] k,
                           input logic [PAY_W-1:0] p);
      int unsigned gap;
      req_type     r;
      gap = $urandom_range(0, req_gap_max);
      r.op = op;
      r.key = k;
      r.payload = p;
      if (gap > 0)
         repeat (gap) @(negedge clock);
      req_data = r;
      req_valid = 1;
      do @(posedge clock); while (req_stall);
      book.predict_op(r);
      sent++;
      @(negedge clock);
      req_valid = 0;
   endtask

   task automatic send_random(input int unsigned enq_pct);
      send_req(($urandom_range(1, 100) <= enq_pct) ? OP_ENQ : OP_DEQ, draw_key(),
               $urandom_range(0, 511));
   endtask

   task automatic wait_drained();
      req_valid = 0;
      while (book.expected_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic receive_results();
      int unsigned hold;
      forever begin
         if (long_hold_req) begin
            hold = LONG_HOLD;
            long_hold_req = 0;
            long_holds++;
         end else begin
            hold = $urandom_range(0, rsp_stall_max);
         end
         if (hold > 0) begin
            rsp_stall = 1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall = 0;
         do @(posedge clock); while (!rsp_valid);
         book.check_result(rsp_data);
         @(negedge clock);
      end
   endtask

   initial begin
      book = new();
      reset = 1;
      req_valid = 0;
      req_data = '0;
      rsp_stall = 0;
      req_gap_max = 5;
      rsp_stall_max = 5;
      long_hold_req = 0;
      long_holds = 0;
      sent = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;
      fork
         receive_results();
      join_none

      // directed: empty dequeue, key and payload extremes, equal keys, full drain
      send_req(OP_DEQ, '1, '1);
      send_req(OP_ENQ, '1, 9'd511);
      send_req(OP_ENQ, '0, 9'd0);
      send_req(OP_ENQ, 32'd100, 9'd1);
      send_req(OP_ENQ, 32'd100, 9'd2);
      send_req(OP_ENQ, 32'd100, 9'd3);
      send_req(OP_ENQ, 32'd50, 9'd4);
      send_req(OP_ENQ, 32'd0, 9'd5);
      send_req(OP_ENQ, 32'h8000_0000, 9'd256);
      send_req(OP_ENQ, 32'h7fff_ffff, 9'd255);
      repeat (10) send_req(OP_DEQ, draw_key(), $urandom_range(0, 511));
      wait_drained();

      // mixed traffic with a long receiver hold-off while requests keep coming
      repeat (40) send_random(60);
      req_gap_max = 0;
      long_hold_req = 1;
      repeat (10) send_random(60);
      req_gap_max = 5;
      repeat (40) send_random(60);
      wait_drained();

      // fill to capacity, first without idling, then overflow
      req_gap_max = 0;
      rsp_stall_max = 0;
      repeat (100) send_random(97);
      req_gap_max = 5;
      rsp_stall_max = 5;
      while (book.fill < DEPTH)
         send_random(97);
      repeat (6) send_req(OP_ENQ, draw_key(), $urandom_range(0, 511));
      wait_drained();

      // drain to empty, then underflow
      req_gap_max = 0;
      while (book.fill > 0)
         send_random(0);
      repeat (4) send_req(OP_DEQ, draw_key(), $urandom_range(0, 511));
      req_gap_max = 5;

      while (sent < ITEM_GOAL)
         send_random(50);

      req_valid = 0;
      while (book.expected_results.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      $display("covered %0d transactions: %0d enqueues (%0d overflowed),", sent,
               book.n_enq, book.n_over);
      $display("%0d dequeues (%0d underflowed), checked %0d results, peak %0d of %0d",
               book.n_deq, book.n_under, book.checked, book.peak, DEPTH);
      $display("%0d long output hold-offs", long_holds);
      if (book.errors == 0 && book.expected_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches, %0d results missing", book.errors,
                  book.expected_results.size());
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/mhpq_pkg.sv
sv/mhpq_store.sv
sv/min_heap_priority_queue.sv
test/tb_min_heap_priority_queue.sv
